/* hw/rtl/smrc_pkg.sv */
// shared types and constants of the stepper move ramp controller
package smrc_pkg;

  localparam logic [2:0] CmdMoveRel = 3'd0;
  localparam logic [2:0] CmdMoveAbs = 3'd1;
  localparam logic [2:0] CmdStop    = 3'd2;
  localparam logic [2:0] CmdHome    = 3'd3;
  localparam logic [2:0] CmdPulse   = 3'd4;

  localparam logic [1:0] RegStart    = 2'd0;
  localparam logic [1:0] RegRampLen  = 2'd1;
  localparam logic [1:0] RegInterval = 2'd2;
  localparam logic [1:0] RegHome     = 2'd3;

  localparam logic [19:0] TickHz = 20'd1000000;
  localparam logic [16:0] MaxHz  = 17'd50000;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StExec,
    StRamp,
    StDiv,
    StDone,
    StOut
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch input transaction
    logic mod_step;   // one step of the ramp interval check
    logic exec;       // apply command, may request a speed update
    logic ramp_start; // start ramp quotient division
    logic div_start;  // start reload division
    logic ramp_step;  // one step of the ramp divider
    logic div_step;   // one step of the reload divider
    logic div_finish; // write reload and compare
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_ramp;  // speed must be recomputed through the ramp formula
    logic need_speed; // speed must be written
    logic div_last;   // divider on its last step
  } dp_status_t;

endpackage

/* hw/rtl/smrc_ctrl.sv */
// controller state machine of the stepper move ramp controller
module smrc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output smrc_pkg::dp_cmd_t     cmd_o,
  input  smrc_pkg::dp_status_t  status_i
);

  smrc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smrc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      smrc_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = smrc_pkg::StMod;
        end
      end
      smrc_pkg::StMod: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.div_last) begin
          state_d = smrc_pkg::StExec;
        end
      end
      smrc_pkg::StExec: begin
        cmd_o.exec = 1'b1;
        if (status_i.need_ramp) begin
          cmd_o.ramp_start = 1'b1;
          state_d = smrc_pkg::StRamp;
        end else if (status_i.need_speed) begin
          state_d = smrc_pkg::StDone;
        end else begin
          state_d = smrc_pkg::StOut;
        end
      end
      smrc_pkg::StRamp: begin
        cmd_o.ramp_step = 1'b1;
        if (status_i.div_last) begin
          state_d = smrc_pkg::StDone;
        end
      end
      smrc_pkg::StDone: begin
        cmd_o.div_start = 1'b1;
        state_d = smrc_pkg::StDiv;
      end
      smrc_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          cmd_o.div_finish = 1'b1;
          state_d = smrc_pkg::StOut;
        end
      end
      smrc_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = smrc_pkg::StIdle;
        end
      end
      default: state_d = smrc_pkg::StIdle;
    endcase
  end

`ifndef SYNTHESIS
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ramp_step, cmd_o.div_step, cmd_o.mod_step, cmd_o.capture}))
    else $error("two datapath phases at once");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
`endif

endmodule

/* hw/rtl/smrc_dp.sv */
// datapath: move state, ramp arithmetic and serial reload divider
module smrc_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smrc_pkg::dp_cmd_t     cmd_i,
  output smrc_pkg::dp_status_t  status_o,
  input  logic [2:0]            command_i,
  input  logic signed [31:0]    amount_i,
  input  logic [15:0]           speed_hz_i,
  input  logic [15:0]           start_freq_i,
  input  logic [7:0]            ramp_pulses_i,
  input  logic [7:0]            ramp_interval_i,
  input  logic [15:0]           home_freq_i,
  output logic [19:0]           reload_value_o,
  output logic [18:0]           compare_value_o,
  output logic                  speed_updated_o,
  output logic                  direction_level_o,
  output logic                  motor_enable_o,
  output logic                  busy_res_o,
  output logic signed [31:0]    position_o,
  output logic signed [1:0]     move_sign_o
);

  logic [2:0]  cmd_q;
  logic [31:0] amt_q;
  logic [15:0] spd_q;
  logic [31:0] goal_q, done_q, pos_q;
  logic        run_q, dirpin_q, en_q, upd_q;
  logic [1:0]  sign_q;
  logic [16:0] now_q;
  logic [15:0] gfreq_q;
  logic [7:0]  rcnt_q;
  logic [19:0] reload_q;
  logic [18:0] compare_q;
  logic        mod_zero_q;
  // shared restoring divider
  logic [23:0] num_q;
  logic [19:0] rem_q;
  logic [19:0] den_q;
  logic [4:0]  dcnt_q;

  // combinational command decode
  logic [31:0] steps;
  logic        do_move;
  logic [15:0] mfreq;
  logic [31:0] done_inc;
  logic        ramp_go;
  logic [7:0]  rcnt_inc;
  logic [16:0] fclamp;
  logic [20:0] rem_sh;
  logic [20:0] rem_sub;

  always_comb begin
    steps   = '0;
    do_move = 1'b0;
    mfreq   = spd_q;
    case (cmd_q)
      smrc_pkg::CmdMoveRel: begin
        steps = amt_q;
        do_move = 1'b1;
      end
      smrc_pkg::CmdMoveAbs: begin
        steps = amt_q - pos_q;
        do_move = 1'b1;
      end
      smrc_pkg::CmdHome: begin
        steps = 32'd0 - pos_q;
        mfreq = home_freq_i;
        do_move = (pos_q != '0) && !pos_q[31];
      end
      default: ;
    endcase
    done_inc = done_q + 32'd1;
    ramp_go  = (now_q < {1'b0, gfreq_q}) && (rcnt_q < ramp_pulses_i);
    rcnt_inc = rcnt_q + 8'd1;
    rem_sh   = {rem_q, num_q[23]};
    rem_sub  = rem_sh - {1'b0, den_q};
  end

  always_comb begin
    fclamp = now_q;
    if (now_q == '0) fclamp = 17'd1;
    if (now_q > smrc_pkg::MaxHz) fclamp = smrc_pkg::MaxHz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q <= '0; done_q <= '0; run_q <= 1'b0; pos_q <= '0; sign_q <= '0;
      now_q <= '0; gfreq_q <= '0; rcnt_q <= '0;
      reload_q <= 20'd999; compare_q <= 19'd500; en_q <= 1'b0; dirpin_q <= 1'b0;
      upd_q <= 1'b0; mod_zero_q <= 1'b0;
      num_q <= '0; rem_q <= '0; den_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        upd_q <= 1'b0;
        // interval check: remainder of the next ramp count by the interval
        num_q  <= {rcnt_inc, 16'd0};
        den_q  <= {12'd0, ramp_interval_i};
        rem_q  <= '0;
        dcnt_q <= 5'd7;
      end
      if (cmd_i.mod_step && dcnt_q == '0) begin
        mod_zero_q <= rem_sub[20] ? (rem_sh[19:0] == '0) : (rem_sub[19:0] == '0);
      end
      if (cmd_i.exec) begin
        if (do_move && steps != '0) begin
          dirpin_q <= steps[31];
          goal_q   <= steps[31] ? 32'd0 - steps : steps;
          sign_q   <= steps[31] ? 2'b11 : 2'b01;
          done_q   <= '0;
          run_q    <= 1'b1;
          gfreq_q  <= mfreq;
          rcnt_q   <= '0;
          now_q    <= {1'b0, (start_freq_i > mfreq) ? mfreq : start_freq_i};
          en_q     <= 1'b1;
          upd_q    <= 1'b1;
        end else if (cmd_q == smrc_pkg::CmdStop) begin
          run_q <= 1'b0; goal_q <= '0; done_q <= '0; sign_q <= '0;
        end else if (cmd_q == smrc_pkg::CmdHome) begin
          if (!do_move) pos_q <= '0;
        end else if (cmd_q == smrc_pkg::CmdPulse && run_q) begin
          pos_q <= (sign_q == 2'b01) ? pos_q + 32'd1 : pos_q - 32'd1;
          if (ramp_go) begin
            rcnt_q <= rcnt_inc;
            if (ramp_interval_i != '0 && mod_zero_q) begin
              upd_q <= 1'b1;
              if (start_freq_i >= gfreq_q) begin
                now_q <= {1'b0, gfreq_q};
              end
            end
          end
          if (done_inc >= goal_q) begin
            run_q <= 1'b0; goal_q <= '0; done_q <= '0;
          end else begin
            done_q <= done_inc;
          end
        end
      end
      if (cmd_i.ramp_start) begin
        // numerator (goal-start)*count, at most 16+8 bits
        num_q  <= 24'(({8'd0, gfreq_q - start_freq_i}) * {16'd0, rcnt_inc});
        den_q  <= {12'd0, ramp_pulses_i};
        rem_q  <= '0;
        dcnt_q <= 5'd23;
      end
      if (cmd_i.div_start) begin
        num_q  <= {smrc_pkg::TickHz, 4'd0};
        den_q  <= {3'd0, fclamp};
        rem_q  <= '0;
        dcnt_q <= 5'd19;
      end
      if (cmd_i.mod_step || cmd_i.ramp_step || cmd_i.div_step) begin
        if (!rem_sub[20]) begin
          rem_q <= rem_sub[19:0];
          num_q <= {num_q[22:0], 1'b1};
        end else begin
          rem_q <= rem_sh[19:0];
          num_q <= {num_q[22:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 5'd1;
      end
      if (cmd_i.ramp_step && dcnt_q == '0) begin
        // quotient in num_q bits after final shift
        if ({1'b0, start_freq_i} + {1'b0, num_q[14:0], !rem_sub[20]} >
            {1'b0, gfreq_q}) begin
          now_q <= {1'b0, gfreq_q};
        end else begin
          now_q <= {1'b0, start_freq_i} + {1'b0, num_q[14:0], !rem_sub[20]};
        end
      end
      if (cmd_i.div_finish) begin
        if ({num_q[18:0], !rem_sub[20]} < 20'd2) begin
          reload_q  <= 20'd1;
          compare_q <= 19'd1;
        end else begin
          reload_q  <= {num_q[18:0], !rem_sub[20]} - 20'd1;
          compare_q <= num_q[18:0];
        end
      end
    end
  end

  // payload capture needs no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      amt_q <= amount_i;
      spd_q <= speed_hz_i;
    end
  end

  assign status_o.need_ramp  = (cmd_q == smrc_pkg::CmdPulse) && run_q && ramp_go &&
                               ramp_interval_i != '0 && mod_zero_q &&
                               start_freq_i < gfreq_q;
  assign status_o.need_speed = (do_move && steps != '0) ||
                               ((cmd_q == smrc_pkg::CmdPulse) && run_q && ramp_go &&
                                ramp_interval_i != '0 && mod_zero_q);
  assign status_o.div_last   = (dcnt_q == '0);

  assign reload_value_o    = reload_q;
  assign compare_value_o   = compare_q;
  assign speed_updated_o   = upd_q;
  assign direction_level_o = dirpin_q;
  assign motor_enable_o    = en_q;
  assign busy_res_o        = run_q;
  assign position_o        = pos_q;
  assign move_sign_o       = sign_q;

`ifndef SYNTHESIS
  a_done_below_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> done_q < goal_q)
    else $error("pulse count past move length");
  a_idle_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> goal_q == '0 && done_q == '0)
    else $error("idle with pending move");
  a_reload_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload_q != '0)
    else $error("zero reload");
`endif

endmodule

/* hw/rtl/stepper_move_ramp_controller.sv */
// top level of the stepper move ramp controller
// flow: each command runs the 8-step interval check, then execute; a speed
// change adds the 20-step reload division, and the ramp formula adds the
// 24-step ramp division before it; the result waits while the output stalls
// throughput: one transaction at a time, the next accepted the cycle after the
// result leaves
// reset: asynchronous active low, registers to defaults, timer set for 1000 Hz
module stepper_move_ramp_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] amount_i,
  input  logic [15:0]        speed_hz_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [19:0]        reload_value_o,
  output logic [18:0]        compare_value_o,
  output logic               speed_updated_o,
  output logic               direction_level_o,
  output logic               motor_enable_o,
  output logic               busy_res_o,
  output logic signed [31:0] position_o,
  output logic signed [1:0]  move_sign_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [15:0] start_q, home_q;
  logic [7:0]  ramp_len_q, interval_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 16'd150;
      ramp_len_q <= 8'd200;
      interval_q <= 8'd10;
      home_q     <= 16'd300;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        smrc_pkg::RegStart:    start_q    <= pwdata[15:0];
        smrc_pkg::RegRampLen:  ramp_len_q <= pwdata[7:0];
        smrc_pkg::RegInterval: interval_q <= pwdata[7:0];
        smrc_pkg::RegHome:     home_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      smrc_pkg::RegStart:    prdata = {16'd0, start_q};
      smrc_pkg::RegRampLen:  prdata = {24'd0, ramp_len_q};
      smrc_pkg::RegInterval: prdata = {24'd0, interval_q};
      smrc_pkg::RegHome:     prdata = {16'd0, home_q};
      default:               prdata = '0;
    endcase
  end

  smrc_pkg::dp_cmd_t    cmd;
  smrc_pkg::dp_status_t status;

  smrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  smrc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .command_i         (command_i),
    .amount_i          (amount_i),
    .speed_hz_i        (speed_hz_i),
    .start_freq_i      (start_q),
    .ramp_pulses_i     (ramp_len_q),
    .ramp_interval_i   (interval_q),
    .home_freq_i       (home_q),
    .reload_value_o    (reload_value_o),
    .compare_value_o   (compare_value_o),
    .speed_updated_o   (speed_updated_o),
    .direction_level_o (direction_level_o),
    .motor_enable_o    (motor_enable_o),
    .busy_res_o        (busy_res_o),
    .position_o        (position_o),
    .move_sign_o       (move_sign_o)
  );

endmodule

/* test/stepper_move_ramp_controller_tb.sv */
// testbench for the stepper move ramp controller: directed table plus random commands
module stepper_move_ramp_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // command channel
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         command_i = smrc_pkg::CmdStop;
  logic signed [31:0] amount_i = '0;
  logic [15:0]        speed_hz_i = '0;
  // result channel
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [19:0]        reload_value_o;
  logic [18:0]        compare_value_o;
  logic               speed_updated_o;
  logic               direction_level_o;
  logic               motor_enable_o;
  logic               busy_res_o;
  logic signed [31:0] position_o;
  logic signed [1:0]  move_sign_o;
  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stepper_move_ramp_controller dut (.*);

  // one timer status as the block reports it
  typedef struct packed {
    logic [19:0]        reload;
    logic [18:0]        compare;
    logic               updated;
    logic               dir_level;
    logic               enable;
    logic               busy;
    logic signed [31:0] pos;
    logic signed [1:0]  sign;
  } timer_status_t;

  // one row of the directed table; check_fixed marks a hand-typed expectation
  typedef struct {
    logic [2:0]    cmd;
    logic [31:0]   amt;
    logic [15:0]   spd;
    logic          check_fixed;
    timer_status_t fixed;
  } cmd_row_t;

  typedef bit bool_t;

  timer_status_t expected_status_q[$];
  int unsigned   mismatch_count = 0;
  int unsigned   stray_count = 0;
  bool_t         sender_idles = 1;
  bool_t         receiver_idles = 1;
  bit            hold_off = 0;

  // shadow of the controller state
  logic [15:0] m_start_freq;
  logic [7:0]  m_ramp_len;
  logic [7:0]  m_interval;
  logic [15:0] m_home_freq;
  logic [31:0] m_goal_pulses, m_done_pulses, m_position;
  logic        m_running, m_enable, m_dir_pin;
  int          m_sign;
  logic [31:0] m_now_freq, m_goal_freq, m_ramp_count;
  logic [19:0] m_reload;
  logic [18:0] m_compare;

  function automatic void shadow_reset();
    m_start_freq = 16'd150; m_ramp_len = 8'd200; m_interval = 8'd10; m_home_freq = 16'd300;
    m_goal_pulses = '0; m_done_pulses = '0; m_running = 0; m_position = '0;
    m_sign = 0; m_now_freq = '0; m_goal_freq = '0; m_ramp_count = '0;
    m_reload = 20'd999; m_compare = 19'd500; m_enable = 0; m_dir_pin = 0;
  endfunction

  // timer reload and compare for a step frequency
  function automatic void program_timer(logic [31:0] f);
    logic [31:0] div;
    if (f < 1) f = 1;
    if (f > 50000) f = 50000;
    div = 32'd1000000 / f;
    if (div < 2) div = 2;
    m_reload = 20'(div - 1);
    m_compare = 19'(div / 2);
  endfunction

  function automatic void halt_shadow();
    m_running = 0; m_goal_pulses = '0; m_done_pulses = '0; m_sign = 0;
  endfunction

  function automatic bit launch_move(logic [31:0] steps, logic [31:0] freq);
    if (steps == 0) return 0;
    if (m_running) halt_shadow();
    if (!steps[31]) begin
      m_dir_pin = 0; m_goal_pulses = steps; m_sign = 1;
    end else begin
      m_dir_pin = 1; m_goal_pulses = -steps; m_sign = -1;
    end
    m_done_pulses = '0; m_running = 1; m_goal_freq = freq; m_ramp_count = '0;
    m_now_freq = m_start_freq;
    if (m_now_freq > m_goal_freq) m_now_freq = m_goal_freq;
    program_timer(m_now_freq);
    m_enable = 1;
    return 1;
  endfunction

  // pulse finished: advance position and walk the acceleration ramp
  function automatic bit advance_pulse();
    bit upd;
    logic [31:0] f;
    upd = 0;
    if (!m_running) return 0;
    m_done_pulses++;
    if (m_sign > 0) m_position++;
    else m_position--;
    if (m_now_freq < m_goal_freq && m_ramp_count < m_ramp_len) begin
      m_ramp_count++;
      if (m_interval != 0 && (m_ramp_count % m_interval) == 0) begin
        if (m_start_freq >= m_goal_freq) f = m_goal_freq;
        else begin
          f = m_start_freq + (m_goal_freq - m_start_freq) * m_ramp_count / m_ramp_len;
          if (f > m_goal_freq) f = m_goal_freq;
        end
        m_now_freq = f;
        program_timer(f);
        upd = 1;
      end
    end
    if (m_done_pulses >= m_goal_pulses) begin
      m_running = 0; m_goal_pulses = '0; m_done_pulses = '0;
    end
    return upd;
  endfunction

  function automatic timer_status_t predict_status(logic [2:0] cmd, logic [31:0] amt,
                                                   logic [15:0] spd);
    timer_status_t s;
    bit upd;
    upd = 0;
    case (cmd)
      smrc_pkg::CmdMoveRel: upd = launch_move(amt, {16'd0, spd});
      smrc_pkg::CmdMoveAbs: upd = launch_move(amt - m_position, {16'd0, spd});
      smrc_pkg::CmdStop:    halt_shadow();
      smrc_pkg::CmdHome: begin
        if (m_position == 0 || m_position[31]) m_position = '0;
        else upd = launch_move(-m_position, {16'd0, m_home_freq});
      end
      smrc_pkg::CmdPulse:   upd = advance_pulse();
      default: ;
    endcase
    s.reload = m_reload; s.compare = m_compare; s.updated = upd;
    s.dir_level = m_dir_pin; s.enable = m_enable; s.busy = m_running;
    s.pos = m_position;
    s.sign = (m_sign > 0) ? 2'sd1 : ((m_sign < 0) ? -2'sd1 : 2'sd0);
    return s;
  endfunction

  // register write, setup then access phase
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      smrc_pkg::RegStart:    m_start_freq = val[15:0];
      smrc_pkg::RegRampLen:  m_ramp_len = val[7:0];
      smrc_pkg::RegInterval: m_interval = val[7:0];
      default:               m_home_freq = val[15:0];
    endcase
  endtask

  // one transaction on the command channel, with an optional idle burst first
  task automatic send_cmd(logic [2:0] cmd, logic [31:0] amt, logic [15:0] spd,
                          bit fixed_ok, timer_status_t fixed);
    timer_status_t s;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    command_i <= cmd; amount_i <= amt; speed_hz_i <= spd; in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    s = predict_status(cmd, amt, spd);
    if (fixed_ok) expected_status_q.push_back(fixed);
    else expected_status_q.push_back(s);
  endtask

  task automatic settle();
    in_valid_i <= 0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // result checker against the oldest expectation
  always @(posedge clk_i) begin
    timer_status_t got, exp_s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{reload_value_o, compare_value_o, speed_updated_o, direction_level_o,
              motor_enable_o, busy_res_o, position_o, move_sign_o};
      if (expected_status_q.size() == 0) begin
        stray_count++;
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with nothing expected: %p", got);
      end else begin
        exp_s = expected_status_q.pop_front();
        if (got !== exp_s) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p got %p", exp_s, got);
        end
      end
    end
  end

  // receiver stall: random bursts, one long hold-off, none when idling is off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 0;
        hold_off = 0;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  // random command, mostly well-formed moves and pulses to drive the ramp
  task automatic random_cmd();
    logic [2:0]  cmd;
    logic [31:0] amt;
    int unsigned r;
    r = $urandom_range(0, 99);
    amt = $urandom_range(1, 40);
    if ($urandom_range(0, 1)) amt = -amt;
    if (r < 60) cmd = smrc_pkg::CmdPulse;
    else if (r < 70) cmd = smrc_pkg::CmdMoveRel;
    else if (r < 76) begin
      cmd = smrc_pkg::CmdMoveAbs; amt = m_position + amt;
    end else if (r < 80) cmd = smrc_pkg::CmdStop;
    else if (r < 84) cmd = smrc_pkg::CmdHome;
    else if (r < 87) cmd = 3'($urandom_range(5, 7));
    else if (r < 93) begin
      cmd = 3'($urandom_range(0, 1)); amt = $urandom;
    end else cmd = smrc_pkg::CmdMoveRel;
    send_cmd(cmd, amt, 16'($urandom), 0, '0);
  endtask

  cmd_row_t dir_table[] = '{
    // status right after reset: stop and pulse while idle
    '{smrc_pkg::CmdStop,  32'd0, 16'd0, 1,
      '{20'd999, 19'd500, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 2'sd0}},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 1,
      '{20'd999, 19'd500, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 2'sd0}},
    // zero-length moves change nothing
    '{smrc_pkg::CmdMoveRel, 32'd0, 16'd500, 1,
      '{20'd999, 19'd500, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 2'sd0}},
    '{smrc_pkg::CmdMoveAbs, 32'd0, 16'd500, 1,
      '{20'd999, 19'd500, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 2'sd0}},
    // home at zero
    '{smrc_pkg::CmdHome, 32'd0, 16'd0, 1,
      '{20'd999, 19'd500, 1'b0, 1'b0, 1'b0, 1'b0, 32'sd0, 2'sd0}},
    // unknown commands
    '{3'd5, 32'hFFFF_FFFF, 16'hFFFF, 0, '0},
    '{3'd6, 32'h8000_0000, 16'h0, 0, '0},
    '{3'd7, 32'h7FFF_FFFF, 16'h8000, 0, '0},
    // zero speed gives 1 Hz
    '{smrc_pkg::CmdMoveRel, 32'd3, 16'd0, 1,
      '{20'd999999, 19'd500000, 1'b1, 1'b0, 1'b1, 1'b1, 32'sd0, 2'sd1}},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 0, '0},
    // move while busy, largest backward move, fastest speed
    '{smrc_pkg::CmdMoveRel, 32'h8000_0000, 16'hFFFF, 0, '0},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdMoveRel, 32'h7FFF_FFFF, 16'd50000, 0, '0},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdStop, 32'd0, 16'd0, 0, '0},
    // home from positive, then from negative
    '{smrc_pkg::CmdMoveAbs, 32'd5, 16'd1000, 0, '0},
    '{smrc_pkg::CmdHome, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdMoveAbs, -32'sd2, 16'd1, 0, '0},
    '{smrc_pkg::CmdPulse, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdHome, 32'd0, 16'd0, 0, '0},
    '{smrc_pkg::CmdStop, 32'd0, 16'd0, 0, '0}
  };

  // register settings per phase, extremes included
  logic [15:0] ph_start[6]    = '{16'd150, 16'd1, 16'd0, 16'd50000, 16'hFFFF, 16'd400};
  logic [7:0]  ph_len[6]      = '{8'd200, 8'd1, 8'd0, 8'd255, 8'd3, 8'd20};
  logic [7:0]  ph_interval[6] = '{8'd10, 8'd1, 8'd0, 8'd255, 8'd2, 8'd1};
  logic [15:0] ph_home[6]     = '{16'd300, 16'd1, 16'd0, 16'd50000, 16'hFFFF, 16'd2000};

  initial begin
    shadow_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (dir_table[i])
      send_cmd(dir_table[i].cmd, dir_table[i].amt, dir_table[i].spd,
               dir_table[i].check_fixed, dir_table[i].fixed);
    settle();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(smrc_pkg::RegStart, ph_start[ph]);
      write_reg(smrc_pkg::RegRampLen, ph_len[ph]);
      write_reg(smrc_pkg::RegInterval, ph_interval[ph]);
      write_reg(smrc_pkg::RegHome, ph_home[ph]);
      // a start change mid-move: raise start above a running target
      if (ph == 5) begin
        send_cmd(smrc_pkg::CmdMoveRel, 32'd50, 16'd300, 0, '0);
        settle();
        write_reg(smrc_pkg::RegStart, 16'd1000);
        repeat (12) send_cmd(smrc_pkg::CmdPulse, '0, '0, 0, '0);
        settle();
        write_reg(smrc_pkg::RegStart, ph_start[ph]);
      end
      if (ph == 2) hold_off = 1;
      if (ph == 5) begin
        sender_idles = 0; receiver_idles = 0;
      end
      repeat (255) random_cmd();
      settle();
    end
    if (mismatch_count == 0 && expected_status_q.size() == 0)
      $display("PASS stepper_move_ramp_controller");
    else
      $display("FAIL stepper_move_ramp_controller");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL stepper_move_ramp_controller");
    $finish;
  end
endmodule
